// File: hdl/bgd_pkg.sv
// ---------------------------------------------------------------------------
// Button gesture decoder package
// Shared types, codes and widths for the button gesture decoder.
// ---------------------------------------------------------------------------
package bgd_pkg;

   localparam int TimeWidth = 32;
   localparam int HoldWidth = 16;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth = 16;

   typedef enum logic [1:0] {
      CMD_UPDATE = 2'd0,
      CMD_SEED   = 2'd1,
      CMD_TAKE   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      GESTURE_NONE   = 2'd0,
      GESTURE_SHORT  = 2'd1,
      GESTURE_DOUBLE = 2'd2,
      GESTURE_LONG   = 2'd3
   } gesture_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_DOUBLE_ENABLE = 2'd0,
      CSR_DOUBLE_GAP    = 2'd1,
      CSR_LONG_HOLD     = 2'd2,
      CSR_UNUSED        = 2'd3
   } csr_index_type;

   localparam logic [HoldWidth-1:0] DoubleGapReset = 16'd300;
   localparam logic [HoldWidth-1:0] LongHoldReset  = 16'd800;

   typedef struct packed {
      logic                 double_enable;
      logic [HoldWidth-1:0] double_gap;
      logic [HoldWidth-1:0] long_hold;
   } cfg_type;

   typedef struct packed {
      cmd_type              cmd;
      logic [TimeWidth-1:0] now_time;
      logic                 level;
   } req_item_type;

   typedef struct packed {
      logic                 prev_level;
      logic [TimeWidth-1:0] press_start;
      logic [TimeWidth-1:0] short_deadline;
      logic                 short_waiting;
      logic                 long_done;
      logic                 short_blocked;
      logic                 short_flag;
      logic                 double_flag;
      logic                 long_flag;
   } state_type;

endpackage

// File: hdl/bgd_if.sv
// ---------------------------------------------------------------------------
// Button gesture decoder channels
// Valid/ready channel interfaces for requests and responses.
// ---------------------------------------------------------------------------
interface bgd_req_if;
   import bgd_pkg::*;

   logic                 valid;
   logic                 ready;
   cmd_type              cmd;
   logic [TimeWidth-1:0] now_time;
   logic                 level;

   modport source (output valid, output cmd, output now_time, output level, input ready);
   modport sink   (input valid, input cmd, input now_time, input level, output ready);
endinterface

interface bgd_rsp_if;
   import bgd_pkg::*;

   logic        valid;
   logic        ready;
   gesture_type gesture;

   modport source (output valid, output gesture, input ready);
   modport sink   (input valid, input gesture, output ready);
endinterface

// File: hdl/bgd_csr.sv
// ---------------------------------------------------------------------------
// Button gesture decoder configuration registers
// Holds the double-click enable, gap window and long-press hold time.
// ---------------------------------------------------------------------------
module bgd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [bgd_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [bgd_pkg::CsrDataWidth-1:0]  csr_wdata,
   output bgd_pkg::cfg_type                  cfg
);
   import bgd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_DOUBLE_ENABLE: cfg_in.double_enable = csr_wdata[0];
            CSR_DOUBLE_GAP:    cfg_in.double_gap = csr_wdata[HoldWidth-1:0];
            CSR_LONG_HOLD:     cfg_in.long_hold = csr_wdata[HoldWidth-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.double_enable <= 1'b1;
         cfg_ff.double_gap <= DoubleGapReset;
         cfg_ff.long_hold <= LongHoldReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hdl/bgd_engine.sv
// ---------------------------------------------------------------------------
// Button gesture decoder engine
// Edge detection, hold and gap timing, event flags and the take arbiter.
// ---------------------------------------------------------------------------
module bgd_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  bgd_pkg::req_item_type item,
   input  bgd_pkg::cfg_type      cfg,
   output bgd_pkg::gesture_type  gesture
);
   import bgd_pkg::*;

   state_type            state_ff;
   state_type            state_in;
   state_type            upd;
   logic [TimeWidth-1:0] gap_diff;
   logic [TimeWidth-1:0] hold_diff;
   logic [TimeWidth-1:0] expiry_diff;
   logic                 rising;
   logic                 falling;

   // Update path: edges first, then the long check and the window expiry,
   // each seeing the values the earlier steps left.
   always_comb begin
      upd = state_ff;
      rising = !state_ff.prev_level && item.level;
      falling = state_ff.prev_level && !item.level;
      gap_diff = item.now_time - state_ff.short_deadline;
      if (rising) begin
         if (cfg.double_enable && state_ff.short_waiting &&
             ((gap_diff == '0) || gap_diff[TimeWidth-1])) begin
            upd.short_waiting = 1'b0;
            upd.short_blocked = 1'b1;
            upd.double_flag = 1'b1;
         end else begin
            upd.short_blocked = 1'b0;
         end
         upd.press_start = item.now_time;
         upd.long_done = 1'b0;
      end else if (falling) begin
         if (!state_ff.short_blocked && !state_ff.long_done) begin
            if (cfg.double_enable) begin
               upd.short_deadline = item.now_time +
                                    {{(TimeWidth-HoldWidth){1'b0}}, cfg.double_gap};
               upd.short_waiting = 1'b1;
            end else begin
               upd.short_flag = 1'b1;
            end
         end
      end

      hold_diff = item.now_time - upd.press_start;
      if (item.level && !upd.long_done &&
          (hold_diff >= {{(TimeWidth-HoldWidth){1'b0}}, cfg.long_hold})) begin
         upd.long_done = 1'b1;
         upd.long_flag = 1'b1;
      end

      expiry_diff = item.now_time - upd.short_deadline;
      if (upd.short_waiting && !expiry_diff[TimeWidth-1]) begin
         upd.short_waiting = 1'b0;
         upd.short_flag = 1'b1;
      end

      upd.prev_level = item.level;
   end

   always_comb begin
      state_in = state_ff;
      gesture = GESTURE_NONE;
      unique case (item.cmd)
         CMD_UPDATE: state_in = upd;
         CMD_SEED: begin
            state_in = '0;
            state_in.prev_level = item.level;
            state_in.press_start = item.now_time;
         end
         CMD_TAKE: begin
            if (state_ff.long_flag) begin
               state_in.long_flag = 1'b0;
               gesture = GESTURE_LONG;
            end else if (state_ff.double_flag) begin
               state_in.double_flag = 1'b0;
               gesture = GESTURE_DOUBLE;
            end else if (state_ff.short_flag) begin
               state_in.short_flag = 1'b0;
               gesture = GESTURE_SHORT;
            end
         end
         default: state_in = state_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/button_gesture_decoder_core.sv
// ---------------------------------------------------------------------------
// Button gesture decoder core
// Turns timestamped button levels into short, double and long gestures.
// ---------------------------------------------------------------------------
// Usage:
//   The req channel carries one command per transfer: update with a level
//   sample, seed a new baseline, take one latched gesture, or do nothing.
//   Every request gives exactly one transfer on the rsp channel, in order;
//   its gesture is nonzero only for a take.
//   The csr port writes double_enable, double_gap and long_hold, one per
//   cycle, and should be used only while no request is in flight.
//   A request passes through the input register and then the response
//   register; its response is valid once it reaches the response register.
//   Throughput is one request per cycle while rsp.ready holds; the state
//   update, a few 32-bit adds and compares, completes in the cycle the
//   request leaves the input register.
//   When the receiver stalls, the response register holds its item and the
//   input register keeps one more request, after which req.ready drops.
//   Synchronous reset empties both registers, clears all gesture state and
//   restores the configuration defaults (double mode on, 300 ms gap,
//   800 ms hold).
// ---------------------------------------------------------------------------
module button_gesture_decoder_core (
   input  logic                              clock,
   input  logic                              reset,
   bgd_req_if.sink                           req,
   bgd_rsp_if.source                         rsp,
   input  logic                              csr_wr_en,
   input  logic [bgd_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [bgd_pkg::CsrDataWidth-1:0]  csr_wdata
);
   import bgd_pkg::*;

   cfg_type      cfg;
   logic         s1_valid_ff;
   logic         s1_valid_in;
   req_item_type s1_item_ff;
   logic         out_valid_ff;
   logic         out_valid_in;
   gesture_type  out_gesture_ff;
   gesture_type  gesture;
   logic         advance;
   logic         req_xfer;
   logic         fire;

   bgd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bgd_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .item    (s1_item_ff),
      .cfg     (cfg),
      .gesture (gesture)
   );

   // The response register can take a new item when it is empty or its
   // current item is being transferred out.
   assign advance = !out_valid_ff || rsp.ready;
   assign fire = s1_valid_ff && advance;
   assign req.ready = !s1_valid_ff || advance;
   assign req_xfer = req.valid && req.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = advance ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_item_ff.cmd <= req.cmd;
         s1_item_ff.now_time <= req.now_time;
         s1_item_ff.level <= req.level;
      end
      if (fire) begin
         out_gesture_ff <= gesture;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.gesture = out_gesture_ff;

endmodule
